// ----- hdl/mp3w_pkg.sv -----
// ----------------------------------------------------------------------------
// mp3w_pkg
// Shared types, constants and helpers of the 3D max pooling block.
// ----------------------------------------------------------------------------
package mp3w_pkg;

  localparam int MAX_VOXELS  = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_BITS   = $clog2(MAX_VOXELS);
  localparam int CNT_BITS    = ADDR_BITS + 1;
  localparam int REG_BITS    = 31;
  localparam int IDX_BITS    = 2;

  // Register indexes
  localparam logic [IDX_BITS-1:0] REG_DEPTH  = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_WIDTH  = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_CEIL   = 2'd3;

  localparam logic [REG_BITS-1:0] AXIS_RESET = 31'd8321;

  // Input kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_PRODUCE = 1'b1;

  typedef struct packed {
    logic [6:0] size;
    logic [5:0] kernel;
    logic [5:0] stride;
    logic [5:0] pad0;
    logic [5:0] pad1;
  } axis_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;     // latch window bounds for current position
    logic step;      // set origin, or advance the walk and issue one read
    logic finish;    // advance position, flag last of volume
    logic load;      // write one sample
    logic restart;   // clear position and load address
    logic present;   // move result into the output register
  } mp3w_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty_sizes; // some pooled size is zero
    logic walk_done;   // last read of the window issued (or none)
  } mp3w_sts_t;

  function automatic axis_t unpack_axis(input logic [REG_BITS-1:0] r);
    axis_t a;
    a.size   = r[6:0];
    a.kernel = r[12:7];
    a.stride = (r[18:13] == 6'd0) ? 6'd1 : r[18:13];
    a.pad0   = r[24:19];
    a.pad1   = r[30:25];
    return a;
  endfunction

endpackage

// ----- hdl/max_pool_3d_window_core.sv -----
// A load is written to the voxel store when taken. A produce walks its clipped
// window with one store read per cycle, then moves its result into the output
// register; input reopens while a result waits there, but no new item is taken
// before that. A configuration write reruns the pooled size division.
// Synchronous rst restores default registers and restarts the volume; the voxel
// store is not cleared.
// ----------------------------------------------------------------------------
// max_pool_3d_window_core
// Top level of the 3D max pooling block.
// ----------------------------------------------------------------------------
module max_pool_3d_window_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] pooled_max
  output logic        m_tlast,   // last_of_volume
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);
  import mp3w_pkg::*;

  logic [REG_BITS-1:0] reg_d, reg_h, reg_w;
  logic                reg_ceil;
  axis_t               ax_d, ax_h, ax_w;
  logic                any_pad, sizes_go;
  logic [2:0]          sdone;
  logic [2:0]          sdone_seen;
  logic [7:0]          sz_d, sz_h, sz_w;
  mp3w_cmd_t           cmd;
  mp3w_sts_t           sts;
  logic signed [15:0]  best;
  logic                last;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_d <= AXIS_RESET; reg_h <= AXIS_RESET; reg_w <= AXIS_RESET;
      reg_ceil <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEPTH:  reg_d <= cfg_data;
        REG_HEIGHT: reg_h <= cfg_data;
        REG_WIDTH:  reg_w <= cfg_data;
        REG_CEIL:   reg_ceil <= cfg_data[0];
        default:    reg_ceil <= reg_ceil;
      endcase
    end
  end

  assign ax_d = unpack_axis(reg_d);
  assign ax_h = unpack_axis(reg_h);
  assign ax_w = unpack_axis(reg_w);
  assign any_pad = |{ax_d.pad0, ax_d.pad1, ax_h.pad0, ax_h.pad1, ax_w.pad0, ax_w.pad1};

  mp3w_size_calc u_sd (.clk, .rst, .go(sizes_go), .axis(ax_d), .any_pad,
    .round_up(reg_ceil), .done(sdone[0]), .pooled(sz_d));
  mp3w_size_calc u_sh (.clk, .rst, .go(sizes_go), .axis(ax_h), .any_pad,
    .round_up(reg_ceil), .done(sdone[1]), .pooled(sz_h));
  mp3w_size_calc u_sw (.clk, .rst, .go(sizes_go), .axis(ax_w), .any_pad,
    .round_up(reg_ceil), .done(sdone[2]), .pooled(sz_w));

  // Track completion of all three axis dividers
  always_ff @(posedge clk) begin
    if (rst || sizes_go) sdone_seen <= '0;
    else sdone_seen <= sdone_seen | sdone;
  end

  mp3w_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_tvalid), .in_kind(s_tuser), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .cfg_written(cfg_we),
    .sizes_done(&(sdone_seen | sdone) && !sizes_go),
    .sizes_go, .cmd, .sts
  );

  mp3w_datapath u_dp (
    .clk, .rst, .cmd, .sts,
    .sample(s_tdata),
    .ax_d, .ax_h, .ax_w,
    .size_d(sz_d), .size_h(sz_h), .size_w(sz_w),
    .rd_valid(1'b1),
    .res_max(best), .res_last(last)
  );

  assign m_tdata = best;
  assign m_tlast = last;
endmodule

// ----- hdl/mp3w_size_calc.sv -----
// ----------------------------------------------------------------------------
// mp3w_size_calc
// Computes the pooled size of one axis from its setup, by repeated
// subtraction (one stride per cycle; span below 256).
// ----------------------------------------------------------------------------
module mp3w_size_calc (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  mp3w_pkg::axis_t      axis,
  input  logic                 any_pad,
  input  logic                 round_up,
  output logic                 done,
  output logic [7:0]           pooled
);
  import mp3w_pkg::*;

  // span = size+pad0+pad1-kernel, signed 10 bits
  logic signed [9:0] num;
  logic [9:0]        rem;
  logic [8:0]        quo;
  logic              neg;
  logic              busy;
  logic [5:0]        s;
  logic signed [10:0] p;
  logic [8:0]        lim;
  logic signed [16:0] prod;

  assign s = axis.stride;
  assign num = $signed({3'd0, axis.size}) + $signed({4'd0, axis.pad0})
             + $signed({4'd0, axis.pad1}) - $signed({4'd0, axis.kernel});

  // Final adjust once quotient magnitude is known
  always_comb begin
    logic [8:0] q_up;
    q_up = quo + ((rem != 10'd0) ? 9'd1 : 9'd0);
    if (!neg) p = $signed({2'b0, (round_up ? q_up : quo)}) + 11'sd1;
    else      p = -$signed({2'b0, (round_up ? quo : q_up)}) + 11'sd1;
    lim  = {2'b0, axis.size} + {3'b0, axis.pad0};
    prod = $signed({6'd0, p}) * $signed({11'd0, s}) - $signed({11'd0, s});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        neg  <= num[9];
        rem  <= num[9] ? 10'(-num) : 10'(num);
        quo  <= 9'd0;
      end else if (busy) begin
        if (rem >= {4'd0, s}) begin
          rem <= rem - {4'd0, s};
          quo <= quo + 9'd1;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
          if (any_pad && p > 0 && prod >= $signed({8'd0, lim})) begin
            pooled <= (p - 1 > 255) ? 8'd255 : 8'(p - 1);
          end else if (p < 0) begin
            pooled <= 8'd0;
          end else begin
            pooled <= (p > 255) ? 8'd255 : 8'(p);
          end
        end
      end
    end
  end
endmodule

// ----- hdl/mp3w_datapath.sv -----
// ----------------------------------------------------------------------------
// mp3w_datapath
// Voxel store, window bounds, window walk, running maximum and position.
// ----------------------------------------------------------------------------
module mp3w_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  mp3w_pkg::mp3w_cmd_t                   cmd,
  output mp3w_pkg::mp3w_sts_t                   sts,
  input  logic signed [mp3w_pkg::SAMPLE_BITS-1:0] sample,
  input  mp3w_pkg::axis_t                       ax_d,
  input  mp3w_pkg::axis_t                       ax_h,
  input  mp3w_pkg::axis_t                       ax_w,
  input  logic [7:0]                            size_d,
  input  logic [7:0]                            size_h,
  input  logic [7:0]                            size_w,
  input  logic                                  rd_valid,
  output logic signed [mp3w_pkg::SAMPLE_BITS-1:0] res_max,
  output logic                                  res_last
);
  import mp3w_pkg::*;

  logic signed [SAMPLE_BITS-1:0] mem [MAX_VOXELS];
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic signed [SAMPLE_BITS-1:0] rd_val;
  logic signed [SAMPLE_BITS-1:0] best;
  logic                          last;
  logic                          rd_oob;
  logic [CNT_BITS-1:0]           load_cnt;
  logic [7:0]                    pos_d, pos_h, pos_w;
  logic [6:0]                    d0, d1, h0, h1, w0, w1, d, h, w;
  logic [13:0]                   row_dh;   // d*size_h + h
  logic [20:0]                   addr;
  logic                          rd_in;
  logic                          walking;

  assign sts.empty_sizes = (size_d == 8'd0) || (size_h == 8'd0) || (size_w == 8'd0);
  assign sts.walk_done   = !walking;

  // Window bounds for one axis, clipped to the volume
  function automatic logic [13:0] bounds(input axis_t a, input logic [7:0] pos);
    logic signed [15:0] st, en;
    logic [6:0] lo, hi;
    st = $signed({8'd0, pos}) * $signed({10'd0, a.stride}) - $signed({10'd0, a.pad0});
    en = st + $signed({10'd0, a.kernel});
    if (en > $signed({9'd0, a.size})) en = $signed({9'd0, a.size});
    if (st < 0) st = 16'sd0;
    lo = (st > $signed({9'd0, a.size})) ? a.size : 7'(st);
    hi = (en < 0) ? 7'd0 : 7'(en);
    return {lo, hi};
  endfunction

  // Memory: write on load, one registered read per walk step
  always_ff @(posedge clk) begin
    if (cmd.load && !load_cnt[ADDR_BITS]) mem[load_cnt[ADDR_BITS-1:0]] <= sample;
    rd_data <= mem[addr[ADDR_BITS-1:0]];
    rd_oob  <= addr >= 21'(MAX_VOXELS);
  end

  assign addr = 21'(row_dh) * 21'(ax_w.size) + 21'(w);

  // Voxels past the store read as zero
  assign rd_val = rd_oob ? '0 : rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_cnt <= '0;
      pos_d <= '0; pos_h <= '0; pos_w <= '0;
      walking <= 1'b0;
      rd_in <= 1'b0;
      last <= 1'b0;
    end else begin
      rd_in <= 1'b0;
      if (cmd.restart) begin
        load_cnt <= '0;
        pos_d <= '0; pos_h <= '0; pos_w <= '0;
      end
      if (cmd.load && !load_cnt[ADDR_BITS]) load_cnt <= load_cnt + 1'b1;
      // Latch bounds, clear running maximum and walk state
      if (cmd.start) begin
        {d0, d1} <= bounds(ax_d, pos_d);
        {h0, h1} <= bounds(ax_h, pos_h);
        {w0, w1} <= bounds(ax_w, pos_w);
        best <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        walking <= 1'b0;
      end
      if (cmd.step) begin
        if (!walking) begin
          // first step: set up origin
          d <= d0; h <= h0; w <= w0;
          row_dh <= 14'(d0) * 14'(ax_h.size) + 14'(h0);
          walking <= (d0 < d1) && (h0 < h1) && (w0 < w1);
        end else begin
          rd_in <= 1'b1;
          if (w + 7'd1 < w1) w <= w + 7'd1;
          else begin
            w <= w0;
            if (h + 7'd1 < h1) begin
              h <= h + 7'd1;
              row_dh <= row_dh + 14'd1;
            end else begin
              h <= h0;
              if (d + 7'd1 < d1) begin
                d <= d + 7'd1;
                row_dh <= 14'(d + 7'd1) * 14'(ax_h.size) + 14'(h0);
              end else walking <= 1'b0;
            end
          end
        end
      end
      if (rd_in && rd_valid && rd_val > best) best <= rd_val;
      // Advance pooled position
      if (cmd.finish) begin
        last <= 1'b0;
        if (9'(pos_w) + 9'd1 >= 9'(size_w)) begin
          pos_w <= '0;
          if (9'(pos_h) + 9'd1 >= 9'(size_h)) begin
            pos_h <= '0;
            if (9'(pos_d) + 9'd1 >= 9'(size_d)) begin
              pos_d <= '0;
              last <= 1'b1;
              load_cnt <= '0;
            end else pos_d <= pos_d + 8'd1;
          end else pos_h <= pos_h + 8'd1;
        end else pos_w <= pos_w + 8'd1;
      end
    end
  end

  // Output register, loaded when the result is presented
  always_ff @(posedge clk) begin
    if (cmd.present) begin
      res_max  <= best;
      res_last <= last;
    end
  end
endmodule

// ----- hdl/mp3w_ctrl.sv -----
// ----------------------------------------------------------------------------
// mp3w_ctrl
// Sequencer: takes items, runs size computation, window walks and output.
// ----------------------------------------------------------------------------
module mp3w_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_kind,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                cfg_written,
  input  logic                sizes_done,
  output logic                sizes_go,
  output mp3w_pkg::mp3w_cmd_t cmd,
  input  mp3w_pkg::mp3w_sts_t sts
);
  import mp3w_pkg::*;

  typedef enum logic [2:0] {S_SIZE, S_IDLE, S_START, S_WALK, S_DRAIN, S_DRAIN2, S_OUT}
    state_t;
  state_t state;
  logic   accept;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  // output register empty or being taken this cycle
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    cmd.load    = accept && (in_kind == KIND_LOAD);
    cmd.restart = cfg_written;
    cmd.start   = (state == S_START);
    cmd.step    = (state == S_WALK) || ((state == S_DRAIN) && !sts.walk_done);
    cmd.finish  = (state == S_DRAIN2);
    cmd.present = (state == S_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SIZE;
      sizes_go  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      sizes_go <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_written) begin
        state    <= S_SIZE;
        sizes_go <= 1'b1;
      end else begin
        unique case (state)
          S_SIZE:   if (sizes_done) state <= S_IDLE;
          S_IDLE:   if (accept && in_kind == KIND_PRODUCE && !sts.empty_sizes)
                      state <= S_START;
          S_START:  state <= S_WALK;
          // first step sets origin; walk_done then falls until last read
          S_WALK:   state <= S_DRAIN;
          S_DRAIN:  state <= sts.walk_done ? S_DRAIN2 : S_DRAIN;
          S_DRAIN2: state <= S_OUT;
          S_OUT: begin
            if (out_free) begin
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end
          end
          default:  state <= S_IDLE;
        endcase
      end
    end
  end
endmodule

// ----- tb/sv/max_pool_3d_window_core_tb.sv -----
// ----------------------------------------------------------------------------
// max_pool_3d_window_core_tb
// Self-checking bench for the 3D max pooling core. Loads voxel volumes and
// requests pooled windows. An in-bench predictor tracks the registers, the
// voxel store and the window position, and every output item is compared
// with the oldest expected pooled value. The first test writes the low store
// entries that every later window can reach, so no request reads an entry
// that was never written.
// ----------------------------------------------------------------------------
module max_pool_3d_window_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mp3w_pkg::*;

  localparam int STORE_DEPTH = 4096;
  localparam int PREFILL     = 256;
  localparam int DRAIN_WAIT  = 400;

  typedef struct {
    logic [15:0] pooled;
    logic        last;
  } pooled_item_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;    // [15:0] sample
  logic        s_tuser;    // kind
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;    // [15:0] pooled_max
  logic        m_tlast;    // last_of_volume
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [30:0] cfg_data;

  max_pool_3d_window_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state
  logic [30:0]        axis_reg [3];
  logic               ceil_reg;
  logic signed [15:0] voxel_mem [STORE_DEPTH];
  int                 load_ptr;
  int                 ax_size [3], ax_kernel [3], ax_stride [3], ax_pad0 [3], ax_pad1 [3];
  int                 pool_count [3];
  int                 pool_pos [3];

  pooled_item_t pending_pooled [$];
  int n_errors = 0;
  int n_checked = 0;
  int n_last = 0;
  int n_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Timeout at %0t", $time);
    $display("** max_pool_3d_window_core: FAILED **");
    $finish;
  end

  // Pooled count per axis from the current registers; restarts the volume
  function automatic void recompute_counts();
    logic any_pad;
    int num, q, p, s;
    any_pad = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ax_size[i]   = axis_reg[i][6:0];
      ax_kernel[i] = axis_reg[i][12:7];
      ax_stride[i] = (axis_reg[i][18:13] == 0) ? 1 : axis_reg[i][18:13];
      ax_pad0[i]   = axis_reg[i][24:19];
      ax_pad1[i]   = axis_reg[i][30:25];
      if (ax_pad0[i] != 0 || ax_pad1[i] != 0) any_pad = 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      num = ax_size[i] + ax_pad0[i] + ax_pad1[i] - ax_kernel[i];
      s = ax_stride[i];
      if (ceil_reg) q = (num >= 0) ? (num + s - 1) / s : -((-num) / s);
      else          q = (num >= 0) ? num / s : -((-num + s - 1) / s);
      p = q + 1;
      if (any_pad && p > 0 && (p - 1) * s >= ax_size[i] + ax_pad0[i]) p--;
      if (p < 0) p = 0;
      if (p > 255) p = 255;
      pool_count[i] = p;
      pool_pos[i] = 0;
    end
    load_ptr = 0;
  endfunction

  // Apply one accepted item to the predictor
  function automatic void predict_item(input logic kind, input logic [15:0] sample);
    int lo [3], hi [3];
    int addr;
    logic signed [15:0] best, v;
    pooled_item_t r;
    if (kind == KIND_LOAD) begin
      if (load_ptr < STORE_DEPTH) begin
        voxel_mem[load_ptr] = sample;
        load_ptr++;
      end
      return;
    end
    if (pool_count[0] == 0 || pool_count[1] == 0 || pool_count[2] == 0) return;
    for (int i = 0; i < 3; i++) begin
      lo[i] = pool_pos[i] * ax_stride[i] - ax_pad0[i];
      hi[i] = lo[i] + ax_kernel[i];
      if (hi[i] > ax_size[i]) hi[i] = ax_size[i];
      if (lo[i] < 0) lo[i] = 0;
    end
    best = 16'sh8000;
    for (int d = lo[0]; d < hi[0]; d++)
      for (int h = lo[1]; h < hi[1]; h++)
        for (int w = lo[2]; w < hi[2]; w++) begin
          addr = (d * ax_size[1] + h) * ax_size[2] + w;
          v = (addr < STORE_DEPTH) ? voxel_mem[addr] : 16'sd0;
          if (v > best) best = v;
        end
    r.last = 1'b0;
    pool_pos[2]++;
    if (pool_pos[2] >= pool_count[2]) begin
      pool_pos[2] = 0;
      pool_pos[1]++;
      if (pool_pos[1] >= pool_count[1]) begin
        pool_pos[1] = 0;
        pool_pos[0]++;
        if (pool_pos[0] >= pool_count[0]) begin
          pool_pos[0] = 0;
          r.last = 1'b1;
          load_ptr = 0;
        end
      end
    end
    r.pooled = best;
    pending_pooled.push_back(r);
  endfunction

  // Output checker
  always @(posedge clk) begin
    pooled_item_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pooled.size() == 0) begin
        $display("%0t: unexpected item pooled=%h last=%b", $time, m_tdata, m_tlast);
        n_errors++;
      end else begin
        e = pending_pooled.pop_front();
        n_checked++;
        if (e.last) n_last++;
        if (m_tdata !== e.pooled) begin
          $display("%0t: pooled_max expected %h actual %h", $time, e.pooled, m_tdata);
          n_errors++;
        end
        if (m_tlast !== e.last) begin
          $display("%0t: last_of_volume expected %b actual %b", $time, e.last, m_tlast);
          n_errors++;
        end
      end
    end
  end

  // Receiver backpressure
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input logic kind, input logic [15:0] sample);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= sample;
    do @(posedge clk); while (!s_tready);
    predict_item(kind, sample);
    n_sent++;
  endtask

  task automatic load_voxel(input logic [15:0] sample);
    send_item(KIND_LOAD, sample);
  endtask

  task automatic request_pooled();
    send_item(KIND_PRODUCE, 16'($urandom));
  endtask

  // Wait until every expected item has come and the core has settled
  task automatic drain_outputs();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pending_pooled.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] value);
    drain_outputs();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CEIL) ceil_reg = value[0];
    else axis_reg[idx] = value;
    recompute_counts();
  endtask

  function automatic logic [30:0] pack_axis(int sz, int k, int st, int p0, int p1);
    return {6'(p1), 6'(p0), 6'(st), 6'(k), 7'(sz)};
  endfunction

  task automatic set_volume(input logic [30:0] d, input logic [30:0] h,
                            input logic [30:0] w, input logic ceil_on);
    write_reg(REG_DEPTH, d);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_CEIL, {30'd0, ceil_on});
  endtask

  // Write the low store entries, then walk a large sparse volume whose
  // later windows lie past the store and read as zero
  task automatic test_store_prefill();
    set_volume(pack_axis(127, 1, 63, 0, 0), pack_axis(127, 1, 63, 0, 0),
               pack_axis(1, 1, 1, 0, 0), 1'b0);
    for (int i = 0; i < PREFILL; i++) load_voxel(16'($urandom));
    repeat (9) request_pooled();
  endtask

  // Extremes and special cases of the window logic
  task automatic test_directed_cases();
    // full-scale samples, stride zero, 2x2x2 volume
    set_volume(pack_axis(2, 2, 0, 0, 0), pack_axis(2, 2, 0, 0, 0),
               pack_axis(2, 2, 0, 0, 0), 1'b0);
    load_voxel(16'h8000); load_voxel(16'h7FFF); load_voxel(16'h0000);
    load_voxel(16'hFFFF); load_voxel(16'h8000); load_voxel(16'h0001);
    load_voxel(16'h5555); load_voxel(16'hAAAA);
    request_pooled();
    // all register fields at their maximum on the depth axis, ceil mode
    set_volume(31'h7FFFFFFF, AXIS_RESET, AXIS_RESET, 1'b1);
    repeat (5) request_pooled();
    // all-zero register: zero-size volume gives empty windows
    set_volume(31'd0, 31'd0, 31'd0, 1'b0);
    repeat (2) request_pooled();
    // kernel beyond the padded span: no windows, requests give nothing
    set_volume(pack_axis(2, 9, 1, 0, 0), AXIS_RESET, AXIS_RESET, 1'b0);
    repeat (2) request_pooled();
    // oversized padding: windows wholly in padding are empty
    set_volume(pack_axis(3, 2, 1, 6, 6), pack_axis(2, 1, 1, 0, 0),
               AXIS_RESET, 1'b1);
    for (int i = 0; i < 6; i++) request_pooled();
    // unknown register indexes do not exist on a 2-bit index; ceil off again
    write_reg(REG_CEIL, 31'd0);
  endtask

  // Random volumes: mostly well-formed loads then requests, some noise
  task automatic test_random_volumes(input int n_items, input int idle_pct,
                                     input int stall_pct);
    int stop_at, n_vox, n_req;
    logic [30:0] r [3];
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      for (int i = 0; i < 3; i++)
        r[i] = ($urandom_range(7) == 0) ? 31'($urandom) :
          pack_axis($urandom_range(6, 1), $urandom_range(4), $urandom_range(3),
                    ($urandom_range(3) == 0) ? $urandom_range(3) : 0,
                    ($urandom_range(3) == 0) ? $urandom_range(3) : 0);
      // keep the random window walks short and inside the written entries
      for (int i = 0; i < 3; i++) begin
        if (r[i][12:7] > 5) r[i][12:7] = 6'($urandom_range(5));
        if (r[i][6:0] > 6) r[i][6:0] = 7'($urandom_range(6, 1));
      end
      set_volume(r[0], r[1], r[2], 1'($urandom));
      n_vox = r[0][6:0] * r[1][6:0] * r[2][6:0];
      if (n_vox > 60) n_vox = 60;
      for (int i = 0; i < n_vox; i++) load_voxel(16'($urandom));
      n_req = pool_count[0] * pool_count[1] * pool_count[2];
      if (n_req > 40) n_req = 40;
      n_req += $urandom_range(2);
      for (int i = 0; i < n_req; i++)
        if ($urandom_range(9) == 0) load_voxel(16'($urandom));
        else request_pooled();
    end
    drain_outputs();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = KIND_LOAD;
    cfg_we = 1'b0;
    cfg_index = REG_DEPTH;
    cfg_data = '0;
    for (int i = 0; i < 3; i++) axis_reg[i] = AXIS_RESET;
    ceil_reg = 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++) voxel_mem[i] = '0;
    recompute_counts();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_store_prefill();
    test_directed_cases();
    test_random_volumes(180, 0, 0);
    test_random_volumes(130, 85, 0);
    test_random_volumes(130, 0, 85);
    test_random_volumes(130, 27, 27);

    drain_outputs();
    $display("Covered windows past the store, padded/clipped/empty windows, floor and ceil");
    $display("sizing; %0d items sent, %0d pooled items checked, %0d volume ends",
             n_sent, n_checked, n_last);
    if (n_errors == 0) begin
      $display("** max_pool_3d_window_core: PASSED **");
    end else begin
      $display("** max_pool_3d_window_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/mp3w_pkg.sv
hdl/mp3w_size_calc.sv
hdl/mp3w_datapath.sv
hdl/mp3w_ctrl.sv
hdl/max_pool_3d_window_core.sv
tb/sv/max_pool_3d_window_core_tb.sv
